FILE: hdl/char_stream_tokenizer_defines.svh
// assertion macros shared by the tokenizer checker
`ifndef CHAR_STREAM_TOKENIZER_DEFINES_SVH
`define CHAR_STREAM_TOKENIZER_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define CST_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tokenizer property violated");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define CST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tokenizer property violated");

`endif

FILE: hdl/cst_pkg.sv
// types, constants and keyword tables of the character stream tokenizer
package cst_pkg;

  localparam int unsigned POS_BITS_DEF = 24;
  localparam int unsigned CHAR_W       = 8;
  localparam int unsigned KIND_W       = 5;
  localparam int unsigned ERR_W        = 2;
  localparam int unsigned ERR_POS_W    = 24;
  localparam int unsigned RES_DEPTH    = 4;
  localparam int unsigned KW_COUNT     = 5;

  typedef enum logic [3:0] {
    LM_IDLE,
    LM_SLASH,
    LM_COMMENT,
    LM_STRING,
    LM_EQ,
    LM_GT,
    LM_LT,
    LM_BANG,
    LM_INT,
    LM_DOT,
    LM_FRAC,
    LM_KEYWORD,
    LM_ERROR
  } lex_mode_e;

  typedef enum logic [KIND_W-1:0] {
    TK_MINUS   = 5'd0,
    TK_PLUS    = 5'd1,
    TK_MUL     = 5'd2,
    TK_ENDLINE = 5'd3,
    TK_COMMENT = 5'd4,
    TK_DIVIDE  = 5'd5,
    TK_LENGTH  = 5'd6,
    TK_STRING  = 5'd7,
    TK_EQU     = 5'd8,
    TK_SET     = 5'd9,
    TK_GEQ     = 5'd10,
    TK_LEQ     = 5'd11,
    TK_NEQ     = 5'd12,
    TK_NUMBER  = 5'd13,
    TK_IF      = 5'd14,
    TK_ELSE    = 5'd15,
    TK_FOR     = 5'd16,
    TK_WHILE   = 5'd17,
    TK_LET     = 5'd18
  } tok_kind_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE,
    ERR_UNKNOWN,
    ERR_STRING,
    ERR_FRACTION
  } err_e;

  // keyword indexes, in token order
  localparam logic [2:0] KW_IF    = 3'd0;
  localparam logic [2:0] KW_ELSE  = 3'd1;
  localparam logic [2:0] KW_FOR   = 3'd2;
  localparam logic [2:0] KW_WHILE = 3'd3;
  localparam logic [2:0] KW_LET   = 3'd4;

  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SP      = 8'h20;
  localparam logic [CHAR_W-1:0] CH_BANG    = 8'h21;
  localparam logic [CHAR_W-1:0] CH_DQUOTE  = 8'h22;
  localparam logic [CHAR_W-1:0] CH_HASH    = 8'h23;
  localparam logic [CHAR_W-1:0] CH_SQUOTE  = 8'h27;
  localparam logic [CHAR_W-1:0] CH_STAR    = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_DOT     = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_SLASH   = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_0       = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9       = 8'h39;
  localparam logic [CHAR_W-1:0] CH_SEMI    = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_LT      = 8'h3C;
  localparam logic [CHAR_W-1:0] CH_EQ      = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_GT      = 8'h3E;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CASE_GAP   = 8'h20;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [ERR_W-1:0]     err;
    logic [ERR_POS_W-1:0] pos;
    logic                 last;
  } res_t;

  // results of one byte, in order; n counts the valid ones
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic logic [2:0] kw_len(input logic [2:0] k);
    logic [2:0] len;
    case (k)
      KW_IF:    len = 3'd2;
      KW_ELSE:  len = 3'd4;
      KW_FOR:   len = 3'd3;
      KW_WHILE: len = 3'd5;
      KW_LET:   len = 3'd3;
      default:  len = 3'd2;
    endcase
    return len;
  endfunction

  function automatic logic [CHAR_W-1:0] kw_char(input logic [2:0] k, input logic [2:0] o);
    logic [CHAR_W-1:0] ch;
    ch = '0;
    case (k)
      KW_IF: begin
        case (o)
          3'd0:    ch = "i";
          3'd1:    ch = "f";
          default: ch = '0;
        endcase
      end
      KW_ELSE: begin
        case (o)
          3'd0:    ch = "e";
          3'd1:    ch = "l";
          3'd2:    ch = "s";
          3'd3:    ch = "e";
          default: ch = '0;
        endcase
      end
      KW_FOR: begin
        case (o)
          3'd0:    ch = "f";
          3'd1:    ch = "o";
          3'd2:    ch = "r";
          default: ch = '0;
        endcase
      end
      KW_WHILE: begin
        case (o)
          3'd0:    ch = "w";
          3'd1:    ch = "h";
          3'd2:    ch = "i";
          3'd3:    ch = "l";
          3'd4:    ch = "e";
          default: ch = '0;
        endcase
      end
      KW_LET: begin
        case (o)
          3'd0:    ch = "l";
          3'd1:    ch = "e";
          3'd2:    ch = "t";
          default: ch = '0;
        endcase
      end
      default: ch = '0;
    endcase
    return ch;
  endfunction

endpackage

FILE: hdl/cst_core.sv
// input register and lexer state machine of the tokenizer
module cst_core #(
  parameter int unsigned POS_BITS = cst_pkg::POS_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         take_i,
  input  logic [cst_pkg::CHAR_W-1:0]   char_i,
  input  logic                         last_i,
  output cst_pkg::push_t               push_o
);

  localparam int unsigned EPW = cst_pkg::ERR_POS_W;

  typedef logic [POS_BITS-1:0] pos_t;

  typedef struct packed {
    cst_pkg::lex_mode_e mode;
    logic [2:0]         kw_sel;
    logic [2:0]         kw_off;
    pos_t               start;
  } lex_st_t;

  typedef struct packed {
    lex_st_t       st;
    logic [1:0]    n;
    cst_pkg::res_t r0;
    cst_pkg::res_t r1;
  } feed_t;

  function automatic feed_t emit(input feed_t f, input cst_pkg::tok_kind_e kind,
                                 input cst_pkg::err_e err, input pos_t pos);
    feed_t         g;
    cst_pkg::res_t r;
    g      = f;
    r.kind = kind;
    r.err  = err;
    r.pos  = EPW'(pos);
    r.last = 1'b0;
    if (f.n == 2'd0) begin
      g.r0 = r;
      g.n  = 2'd1;
    end else if (f.n == 2'd1) begin
      g.r1 = r;
      g.n  = 2'd2;
    end
    return g;
  endfunction

  function automatic feed_t fail(input feed_t f, input cst_pkg::err_e err, input pos_t pos);
    feed_t g;
    g         = emit(f, cst_pkg::TK_MINUS, err, pos);
    g.st.mode = cst_pkg::LM_ERROR;
    return g;
  endfunction

  // one byte through the lexer; flush marks the implied trailing line feed
  function automatic feed_t feed(input lex_st_t st, input logic [cst_pkg::CHAR_W-1:0] c,
                                 input pos_t pos, input logic flush);
    feed_t                     f;
    logic [cst_pkg::CHAR_W-1:0] lc;
    logic                      cont;
    logic                      dig;
    logic                      hit;
    logic [2:0]                sel;
    logic [2:0]                k;
    logic [2:0]                o;
    logic [2:0]                len;
    f    = '0;
    f.st = st;
    cont = 1'b0;
    hit  = 1'b0;
    sel  = cst_pkg::KW_IF;
    lc   = (c inside {[cst_pkg::CH_UPPER_A:cst_pkg::CH_UPPER_Z]}) ? c + cst_pkg::CASE_GAP : c;
    dig  = c inside {[cst_pkg::CH_0:cst_pkg::CH_9]};
    k    = (st.kw_sel < 3'(cst_pkg::KW_COUNT)) ? st.kw_sel : cst_pkg::KW_IF;
    len  = cst_pkg::kw_len(k);
    o    = (st.kw_off < len) ? st.kw_off : 3'd0;

    case (st.mode)
      cst_pkg::LM_ERROR: begin
      end
      cst_pkg::LM_COMMENT: begin
        if (c == cst_pkg::CH_LF) begin
          f         = emit(f, cst_pkg::TK_COMMENT, cst_pkg::ERR_NONE, '0);
          f.st.mode = cst_pkg::LM_IDLE;
        end
      end
      cst_pkg::LM_STRING: begin
        if (flush) begin
          f = fail(f, cst_pkg::ERR_STRING, pos);
        end else if (c == cst_pkg::CH_SQUOTE || c == cst_pkg::CH_DQUOTE) begin
          f         = emit(f, cst_pkg::TK_STRING, cst_pkg::ERR_NONE, '0);
          f.st.mode = cst_pkg::LM_IDLE;
        end
      end
      cst_pkg::LM_SLASH: begin
        if (c == cst_pkg::CH_SLASH) begin
          f.st.mode = cst_pkg::LM_COMMENT;
        end else begin
          f    = emit(f, cst_pkg::TK_DIVIDE, cst_pkg::ERR_NONE, '0);
          cont = 1'b1;
        end
      end
      cst_pkg::LM_EQ: begin
        if (c == cst_pkg::CH_EQ) begin
          f         = emit(f, cst_pkg::TK_EQU, cst_pkg::ERR_NONE, '0);
          f.st.mode = cst_pkg::LM_IDLE;
        end else begin
          f    = emit(f, cst_pkg::TK_SET, cst_pkg::ERR_NONE, '0);
          cont = 1'b1;
        end
      end
      cst_pkg::LM_GT, cst_pkg::LM_LT, cst_pkg::LM_BANG: begin
        if (c == cst_pkg::CH_EQ) begin
          f = emit(f, (st.mode == cst_pkg::LM_GT) ? cst_pkg::TK_GEQ :
                      (st.mode == cst_pkg::LM_LT) ? cst_pkg::TK_LEQ : cst_pkg::TK_NEQ,
                   cst_pkg::ERR_NONE, '0);
          f.st.mode = cst_pkg::LM_IDLE;
        end else begin
          cont = 1'b1;
        end
      end
      cst_pkg::LM_INT: begin
        if (c == cst_pkg::CH_DOT) begin
          f.st.mode = cst_pkg::LM_DOT;
        end else if (!dig) begin
          f    = emit(f, cst_pkg::TK_NUMBER, cst_pkg::ERR_NONE, '0);
          cont = 1'b1;
        end
      end
      cst_pkg::LM_DOT: begin
        if (dig) begin
          f.st.mode = cst_pkg::LM_FRAC;
        end else begin
          f = fail(f, cst_pkg::ERR_FRACTION, pos);
        end
      end
      cst_pkg::LM_FRAC: begin
        if (!dig) begin
          f    = emit(f, cst_pkg::TK_NUMBER, cst_pkg::ERR_NONE, '0);
          cont = 1'b1;
        end
      end
      cst_pkg::LM_KEYWORD: begin
        if (lc == cst_pkg::kw_char(k, o)) begin
          f.st.kw_off = o + 3'd1;
          if (o + 3'd1 >= len) begin
            f = emit(f, cst_pkg::tok_kind_e'(cst_pkg::TK_IF + {2'b00, k}),
                     cst_pkg::ERR_NONE, '0);
            f.st.mode = cst_pkg::LM_IDLE;
          end
        end else begin
          // broken keyword reports its first letter
          f = fail(f, cst_pkg::ERR_UNKNOWN, st.start);
        end
      end
      default: begin
        cont = 1'b1;
      end
    endcase

    // byte that ended a pending token is lexed from idle
    if (cont) begin
      f.st.mode = cst_pkg::LM_IDLE;
      case (c)
        cst_pkg::CH_SP, cst_pkg::CH_LF, cst_pkg::CH_CR, cst_pkg::CH_TAB: begin
        end
        cst_pkg::CH_MINUS: f = emit(f, cst_pkg::TK_MINUS, cst_pkg::ERR_NONE, '0);
        cst_pkg::CH_PLUS:  f = emit(f, cst_pkg::TK_PLUS, cst_pkg::ERR_NONE, '0);
        cst_pkg::CH_STAR:  f = emit(f, cst_pkg::TK_MUL, cst_pkg::ERR_NONE, '0);
        cst_pkg::CH_SEMI:  f = emit(f, cst_pkg::TK_ENDLINE, cst_pkg::ERR_NONE, '0);
        cst_pkg::CH_HASH:  f = emit(f, cst_pkg::TK_LENGTH, cst_pkg::ERR_NONE, '0);
        cst_pkg::CH_SLASH: f.st.mode = cst_pkg::LM_SLASH;
        cst_pkg::CH_SQUOTE, cst_pkg::CH_DQUOTE: f.st.mode = cst_pkg::LM_STRING;
        cst_pkg::CH_EQ:    f.st.mode = cst_pkg::LM_EQ;
        cst_pkg::CH_GT:    f.st.mode = cst_pkg::LM_GT;
        cst_pkg::CH_LT:    f.st.mode = cst_pkg::LM_LT;
        cst_pkg::CH_BANG:  f.st.mode = cst_pkg::LM_BANG;
        default: begin
          if (dig) begin
            f.st.mode = cst_pkg::LM_INT;
          end else begin
            for (int unsigned i = 0; i < cst_pkg::KW_COUNT; i++) begin
              if (!hit && lc == cst_pkg::kw_char(3'(i), 3'd0)) begin
                hit = 1'b1;
                sel = 3'(i);
              end
            end
            if (hit) begin
              f.st.mode   = cst_pkg::LM_KEYWORD;
              f.st.kw_sel = sel;
              f.st.kw_off = 3'd1;
              f.st.start  = pos;
            end else begin
              f = fail(f, cst_pkg::ERR_UNKNOWN, pos);
            end
          end
        end
      endcase
    end
    return f;
  endfunction

  logic                       stg_vld_q;
  logic [cst_pkg::CHAR_W-1:0] stg_char_q;
  logic                       stg_last_q;

  lex_st_t st_q, st_d;
  pos_t    cpos_q, cpos_d;
  pos_t    cpos_inc;
  pos_t    flush_pos;
  feed_t   f_byte;
  feed_t   f_flush;

  always_comb begin : step
    cpos_inc  = (cpos_q != '1) ? cpos_q + pos_t'(1) : cpos_q;
    flush_pos = (cpos_inc != '1) ? cpos_inc + pos_t'(1) : cpos_inc;
    f_byte    = feed(st_q, stg_char_q, cpos_inc, 1'b0);
    f_flush   = feed(f_byte.st, cst_pkg::CH_LF, flush_pos, 1'b1);
  end

  always_comb begin : next_state
    st_d   = st_q;
    cpos_d = cpos_q;
    if (stg_vld_q) begin
      if (stg_last_q) begin
        // end of text: back to the reset state for the next text
        st_d.mode   = cst_pkg::LM_IDLE;
        st_d.kw_sel = '0;
        st_d.kw_off = '0;
        st_d.start  = '0;
        cpos_d      = '0;
      end else begin
        st_d   = f_byte.st;
        cpos_d = cpos_inc;
      end
    end
  end

  always_comb begin : outputs
    logic [1:0] n_byte;
    logic [1:0] n_flush;
    logic [2:0] n_sum;
    logic [1:0] n_tot;
    n_byte  = f_byte.n;
    n_flush = stg_last_q ? f_flush.n : 2'd0;
    n_sum   = {1'b0, n_byte} + {1'b0, n_flush};
    n_tot   = (n_sum > 3'd2) ? 2'd2 : n_sum[1:0];
    push_o.r0 = (n_byte != 2'd0) ? f_byte.r0 : f_flush.r0;
    push_o.r1 = (n_byte == 2'd2) ? f_byte.r1 :
                (n_byte == 2'd1) ? f_flush.r0 : f_flush.r1;
    push_o.r0.last = (n_tot == 2'd1);
    push_o.r1.last = (n_tot == 2'd2);
    push_o.n  = stg_vld_q ? n_tot : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q   <= 1'b0;
      st_q.mode   <= cst_pkg::LM_IDLE;
      st_q.kw_sel <= '0;
      st_q.kw_off <= '0;
      st_q.start  <= '0;
      cpos_q      <= '0;
    end else begin
      stg_vld_q <= take_i;
      st_q      <= st_d;
      cpos_q    <= cpos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      stg_char_q <= char_i;
      stg_last_q <= last_i;
    end
  end

endmodule

FILE: hdl/cst_fifo.sv
// result queue between the lexer and the output channel
module cst_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cst_pkg::push_t push_i,
  input  logic           pop_i,
  output logic           room_o,
  output logic           vld_o,
  output cst_pkg::res_t  head_o
);

  localparam int unsigned DEPTH = cst_pkg::RES_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned LVL_W = CNT_W + 1;

  cst_pkg::res_t    mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic [LVL_W-1:0] lvl;

  // room for one beat in the input register plus a worst case two-result byte
  always_comb begin
    lvl = LVL_W'(cnt_q) - LVL_W'(pop_i) + LVL_W'(push_i.n) + LVL_W'(2);
  end

  assign room_o = (lvl <= LVL_W'(DEPTH));
  assign vld_o  = (cnt_q != '0);
  assign head_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PTR_W'(push_i.n);
      rd_q  <= rd_q + PTR_W'(pop_i);
      cnt_q <= cnt_q - CNT_W'(pop_i) + CNT_W'(push_i.n);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_q + PTR_W'(1)] <= push_i.r1;
    end
  end

endmodule

FILE: hdl/char_stream_tokenizer.sv
// top level of the byte-serial source text tokenizer
//
//   channel | direction | handshake                   | beat
//   --------+-----------+-----------------------------+-------------------------------------
//   in      | to block  | in_valid_i / in_stall_o     | char_code_i, end_of_text_i
//   out     | from block| out_valid_o / out_stall_i   | token_kind_o, error_code_o,
//           |           |                             | error_position_o, last_of_run_o
//
// one byte per cycle while the output is not stalled and each byte yields at most one token; a byte that yields two
// takes two output beats, and the four-entry result queue may then hold input off
// a taken byte passes the input register and then the result queue before it reaches the output
// rst_ni clears the lexer state, position counter and queue at once
// out_stall_i backs up through the result queue into in_stall_o
module char_stream_tokenizer #(
  parameter int unsigned POS_BITS = cst_pkg::POS_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [cst_pkg::CHAR_W-1:0]    char_code_i,
  input  logic                          end_of_text_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [cst_pkg::KIND_W-1:0]    token_kind_o,
  output logic [cst_pkg::ERR_W-1:0]     error_code_o,
  output logic [cst_pkg::ERR_POS_W-1:0] error_position_o,
  output logic                          last_of_run_o
);

  logic           take;
  logic           pop;
  logic           room;
  cst_pkg::push_t push;
  cst_pkg::res_t  head;

  assign take       = in_valid_i && room;
  assign in_stall_o = !room;
  assign pop        = out_valid_o && !out_stall_i;

  cst_core #(
    .POS_BITS(POS_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .char_i (char_code_i),
    .last_i (end_of_text_i),
    .push_o (push)
  );

  cst_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .room_o (room),
    .vld_o  (out_valid_o),
    .head_o (head)
  );

  assign token_kind_o     = head.kind;
  assign error_code_o     = head.err;
  assign error_position_o = head.pos;
  assign last_of_run_o    = head.last;

endmodule

FILE: hdl/cst_checker.sv
// port-level checks of the tokenizer result channel, bound to the top level
`include "char_stream_tokenizer_defines.svh"

module cst_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [cst_pkg::KIND_W-1:0]    token_kind_o,
  input logic [cst_pkg::ERR_W-1:0]     error_code_o,
  input logic [cst_pkg::ERR_POS_W-1:0] error_position_o,
  input logic                          last_of_run_o
);

  logic [cst_pkg::KIND_W+cst_pkg::ERR_W+cst_pkg::ERR_POS_W:0] out_beat;

  assign out_beat = {token_kind_o, error_code_o, error_position_o, last_of_run_o};

  // a stalled beat stays put
  `CST_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_beat))

  // error beats carry kind zero and close their byte's run
  `CST_ASSERT_IMPL(a_err_kind, out_valid_o && error_code_o != cst_pkg::ERR_NONE, token_kind_o == cst_pkg::TK_MINUS && last_of_run_o)

  // token beats carry no position
  `CST_ASSERT_IMPL(a_tok_pos, out_valid_o && error_code_o == cst_pkg::ERR_NONE, error_position_o == '0)

  `CST_ASSERT_IMPL(a_kind_range, out_valid_o, token_kind_o <= cst_pkg::TK_LET)

endmodule

bind char_stream_tokenizer cst_checker u_cst_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .token_kind_o     (token_kind_o),
  .error_code_o     (error_code_o),
  .error_position_o (error_position_o),
  .last_of_run_o    (last_of_run_o)
);
